### hdl/pcp_pkg.sv
// Package for the push constant pooler: item types, status codes, sizes
// and the command/status records between controller and datapath.
// No dependencies.
package pcp_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int USED_W = $clog2(POOL_ENTRIES + 1);

  localparam logic [7:0]  POOL_BASE = 8'hC0;
  localparam logic [31:0] FREE_MARK = 32'h8000_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] script_byte;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [1:0]  status;
    logic [15:0] position;
    logic        final_res;
  } out_item_t;

  typedef struct packed {
    logic ready;
    logic decode;
    logic scan_rd;
    logic scan_cmp;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_lookup;
    logic has_result;
    logic scan_end;
    logic match;
    logic slot_free;
  } dp_status_t;

endpackage

### hdl/pcp_ctrl.sv
// Controller for the push constant pooler: sequences decode, pool scan
// and result transfer. Depends on pcp_pkg.
module pcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  pcp_pkg::dp_status_t stat,
  output pcp_pkg::ctrl_cmd_t  cmd
);
  import pcp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (byte_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          if (stat.go_lookup) state <= S_SCAN_RD;
          else if (stat.has_result) state <= S_EMIT;
          else state <= S_IDLE;
        end
        S_SCAN_RD: begin
          if (stat.scan_end) state <= S_EMIT;
          else state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (stat.match) state <= S_EMIT;
          else state <= S_SCAN_RD;
        end
        S_EMIT: begin
          if (stat.slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.ready    = (state == S_IDLE);
    cmd.decode   = (state == S_DECODE);
    cmd.scan_rd  = (state == S_SCAN_RD);
    cmd.scan_cmp = (state == S_SCAN_CMP);
    cmd.emit     = (state == S_EMIT);
  end

endmodule

### hdl/pcp_dp.sv
// Datapath for the push constant pooler: push assembly, pool memory with
// one read port, result and output registers. Depends on pcp_pkg.
module pcp_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  pcp_pkg::in_item_t   byte_item,
  input  logic                code_ready,
  output logic                code_valid,
  output pcp_pkg::out_item_t  code_item,
  input  pcp_pkg::ctrl_cmd_t  cmd,
  output pcp_pkg::dp_status_t stat
);
  import pcp_pkg::*;

  logic [31:0]       pool [POOL_ENTRIES];
  logic [31:0]       rdata;
  logic [USED_W-1:0] pool_used;
  logic [USED_W-1:0] scan_idx;
  logic [2:0]        push_length;
  logic [2:0]        push_received;
  logic [31:0]       accumulator;
  logic [15:0]       out_count;
  logic [7:0]        byte_r;
  logic              last_r;
  logic [7:0]        res_code;
  logic [1:0]        res_status;

  logic        accept;
  logic        push_open;
  logic        opener;
  logic [2:0]  recv_inc;
  logic [31:0] acc_new;
  logic        complete;

  assign accept    = byte_valid && cmd.ready;
  assign push_open = (push_length != 3'd0);
  assign opener    = (byte_r >= 8'd1) && (byte_r <= 8'd4);
  assign recv_inc  = push_received + 3'd1;
  assign acc_new   = accumulator | ({24'd0, byte_r} << {push_received[1:0], 3'b000});
  assign complete  = push_open && (recv_inc >= push_length);

  always_comb begin
    stat            = '0;
    stat.go_lookup  = complete;
    stat.has_result = push_open ? last_r : (!opener || last_r);
    stat.scan_end   = (scan_idx == pool_used);
    stat.match      = (rdata == accumulator);
    stat.slot_free  = !code_valid || code_ready;
  end

  // pool memory
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      if (stat.scan_end) begin
        if (pool_used != USED_W'(POOL_ENTRIES) && accumulator != FREE_MARK)
          pool[pool_used[IDX_W-1:0]] <= accumulator;
      end else begin
        rdata <= pool[scan_idx[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_used     <= '0;
      push_length   <= '0;
      push_received <= '0;
      accumulator   <= '0;
      out_count     <= '0;
      code_valid    <= 1'b0;
    end else begin
      if (accept) begin
        byte_r <= byte_item.script_byte;
        last_r <= byte_item.last;
        if (byte_item.first) begin
          pool_used     <= '0;
          push_length   <= '0;
          push_received <= '0;
          accumulator   <= '0;
          out_count     <= '0;
        end
      end

      if (cmd.decode) begin
        if (push_open) begin
          if (complete) begin
            accumulator   <= acc_new;
            push_length   <= '0;
            push_received <= '0;
            scan_idx      <= '0;
          end else if (last_r) begin
            accumulator   <= '0;
            push_length   <= '0;
            push_received <= '0;
            res_code      <= 8'd0;
            res_status    <= ST_TRUNC;
          end else begin
            accumulator   <= acc_new;
            push_received <= recv_inc;
          end
        end else if (opener) begin
          if (last_r) begin
            res_code   <= 8'd0;
            res_status <= ST_TRUNC;
          end else begin
            push_length   <= byte_r[2:0];
            push_received <= '0;
            accumulator   <= '0;
          end
        end else begin
          res_code   <= byte_r;
          res_status <= ST_OK;
        end
      end

      if (cmd.scan_rd && stat.scan_end) begin
        accumulator <= '0;
        if (pool_used == USED_W'(POOL_ENTRIES)) begin
          res_code   <= 8'd0;
          res_status <= ST_FULL;
        end else begin
          res_code   <= POOL_BASE + 8'(pool_used);
          res_status <= ST_OK;
          if (accumulator != FREE_MARK) pool_used <= pool_used + 1'b1;
        end
      end

      if (cmd.scan_cmp) begin
        if (stat.match) begin
          accumulator <= '0;
          res_code    <= POOL_BASE + 8'(scan_idx);
          res_status  <= ST_OK;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end

      if (cmd.emit && stat.slot_free) begin
        code_valid          <= 1'b1;
        code_item.code      <= res_code;
        code_item.status    <= res_status;
        code_item.position  <= out_count;
        code_item.final_res <= last_r;
        if (res_status == ST_OK) out_count <= out_count + 16'd1;
      end else if (code_ready) begin
        code_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/push_constant_pooler.sv
// Push constant pooler top level: joins the controller and the datapath.
// Depends on pcp_pkg, pcp_ctrl and pcp_dp.
//
// Takes one script byte per transfer and gives at most one code per byte.
// A plain byte or a flagged push passes through decode and emit, and its code
// is loaded into the output register in emit. A push data byte that gives no
// code passes through decode only. A completed push scans the filled pool
// entries through the single read port of the pool memory, with a read state
// and a compare state per entry. A hit ends the scan at its compare; a miss
// ends it when the scan reaches the pool fill (at most 64). A finished code is
// held in an output register, and the next byte is taken while it waits; a
// further code waits for that register to empty.
module push_constant_pooler (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  pcp_pkg::in_item_t  byte_item,
  output logic               code_valid,
  input  logic               code_ready,
  output pcp_pkg::out_item_t code_item
);
  import pcp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign byte_ready = cmd.ready;

  pcp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  pcp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .code_ready (code_ready),
    .code_valid (code_valid),
    .code_item  (code_item),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
